@@ rtl/sdg_pkg.sv @@
`timescale 1ns / 1ps
// Package for the sidechain ducking gain block: widths, constants, register indexes,
// a unity-saturation helper and the request type of the bit-serial multiplier. No dependencies.
package sdg_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = 24;
   localparam int ENV_FRAC    = 24 - SAMPLE_BITS;
   localparam int ENV_W       = SAMPLE_BITS + ENV_FRAC;
   localparam int GAIN_W      = FRAC_BITS + 1;
   localparam int COEF_W      = 25;
   localparam int HOLD_W      = 20;
   localparam int THR_W       = 16;
   localparam int CSR_W       = 25;
   localparam int CSR_IDX_W   = 3;
   localparam int MUL_W       = GAIN_W;
   localparam int MUL_CNT_W   = $clog2(MUL_W);

   localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << FRAC_BITS;
   localparam logic [MUL_W:0]    HALF  = (MUL_W + 1)'(1) << (FRAC_BITS - 1);

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAIN  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_ATTACK    = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RELEASE   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD      = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] CSR_ENV_DECAY = CSR_IDX_W'(5);

   typedef struct packed {
      logic             start;
      logic [MUL_W-1:0] mcand;
      logic [MUL_W-1:0] mplier;
   } mul_req_type;

   function automatic logic [COEF_W-1:0] sat_unity(input logic [COEF_W-1:0] v);
      logic [COEF_W-1:0] r;
      r = (v > COEF_W'(UNITY)) ? COEF_W'(UNITY) : v;
      return r;
   endfunction

endpackage

@@ rtl/sdg_serial_mul.sv @@
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier with round-half-up by the fraction width.
// Depends on sdg_pkg.
module sdg_serial_mul
   import sdg_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mul_req_type       req,
   output logic [MUL_W-1:0]  prod,
   output logic              done
);

   logic [MUL_W:0]         hi_ff, hi_in;
   logic [MUL_W-1:0]       lo_ff, lo_in;
   logic [MUL_W-1:0]       mcand_ff, mcand_in;
   logic [MUL_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [MUL_W+1:0]       sum;
   logic [2*MUL_W:0]       full;

   // The rounding half is preloaded into the upper half of the accumulator.
   always_comb begin
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {2'b00, mcand_ff} : '0);
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         hi_in    = HALF;
         lo_in    = req.mplier;
         mcand_in = req.mcand;
         cnt_in   = MUL_CNT_W'(MUL_W - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         hi_in = sum[MUL_W+1:1];
         lo_in = {sum[0], lo_ff[MUL_W-1:1]};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - MUL_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      mcand_ff <= mcand_in;
   end

   assign full = {hi_ff, lo_ff};
   assign prod = full[FRAC_BITS +: MUL_W];
   assign done = done_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cnt_ff != '0 |-> !req.start)
      else $error("multiplier restarted while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a finished multiply");
   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("done held longer than one cycle");

endmodule

@@ rtl/sidechain_ducking_gain.sv @@
`timescale 1ns / 1ps
// Sidechain ducker: peak follower, attack/hold/release gain and gain apply.
// An accepted item reaches rsp_valid after up to three passes of the one shared
// bit-serial multiplier, plus control steps; one item is in work at a time, and
// an item is held up at the output step only while rsp_ready holds back the last one.
// Synchronous reset restores register defaults, unity gain and a zero envelope.
module sidechain_ducking_gain
   import sdg_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sidechain_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_program_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [GAIN_W-1:0]             rsp_gain,
   output logic signed [SAMPLE_BITS-1:0] rsp_ducked_sample,
   input  logic                          csr_wr_en,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_ENV   = 8'b0000_0010,
      S_TGT   = 8'b0000_0100,
      S_GSEL  = 8'b0000_1000,
      S_GMUL  = 8'b0001_0000,
      S_CLAMP = 8'b0010_0000,
      S_OMUL  = 8'b0100_0000,
      S_OUT   = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [THR_W-1:0]       thr_ff;
   logic [COEF_W-1:0]      min_gain_ff, attack_ff, release_ff, decay_ff;
   logic [HOLD_W-1:0]      hold_samples_ff;
   logic [ENV_W-1:0]       env_ff, env_in;
   logic [GAIN_W-1:0]      g_ff, g_in;
   logic [GAIN_W-1:0]      target_ff, target_in;
   logic [HOLD_W-1:0]      hold_ff, hold_in;
   logic                   up_ff, up_in;
   logic                   neg_ff, neg_in;
   logic [SAMPLE_BITS-1:0] pmag_ff, pmag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0]      rsp_gain_ff, rsp_gain_in;
   logic [SAMPLE_BITS-1:0] rsp_y_ff, rsp_y_in;

   mul_req_type            mul_req;
   logic [MUL_W-1:0]       mul_prod;
   logic                   mul_done;

   logic [SAMPLE_BITS-1:0] sc_abs;
   logic [ENV_W-1:0]       mag;
   logic [GAIN_W-1:0]      floor_g;
   logic [GAIN_W-1:0]      g_clamp;
   logic                   out_free;
   logic [SAMPLE_BITS-1:0] y_pos;

   sdg_serial_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .prod  (mul_prod),
      .done  (mul_done)
   );

   assign sc_abs   = req_sidechain_sample[SAMPLE_BITS-1] ?
                     (~req_sidechain_sample + SAMPLE_BITS'(1)) : req_sidechain_sample;
   assign mag      = {sc_abs, ENV_FRAC'(0)};
   assign floor_g  = GAIN_W'(sat_unity(min_gain_ff));
   assign g_clamp  = (g_ff < floor_g) ? floor_g : ((g_ff > UNITY) ? UNITY : g_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // The positive result saturates to the largest sample; the negative one never exceeds
   // the most negative sample in magnitude.
   assign y_pos = (mul_prod > MUL_W'((1 << (SAMPLE_BITS - 1)) - 1)) ?
                  SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1) : mul_prod[SAMPLE_BITS-1:0];

   always_comb begin
      state_in       = state_ff;
      env_in         = env_ff;
      g_in           = g_ff;
      target_in      = target_ff;
      hold_in        = hold_ff;
      up_in          = up_ff;
      neg_in         = neg_ff;
      pmag_in        = pmag_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_gain_in    = rsp_gain_ff;
      rsp_y_in       = rsp_y_ff;
      mul_req.start  = 1'b0;
      mul_req.mcand  = '0;
      mul_req.mplier = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               neg_in  = req_program_sample[SAMPLE_BITS-1];
               pmag_in = req_program_sample[SAMPLE_BITS-1] ?
                         (~req_program_sample + SAMPLE_BITS'(1)) : req_program_sample;
               if (mag > env_ff) begin
                  env_in   = mag;
                  state_in = S_TGT;
               end else begin
                  mul_req.start  = 1'b1;
                  mul_req.mcand  = MUL_W'(sat_unity(decay_ff));
                  mul_req.mplier = MUL_W'(env_ff - mag);
                  state_in       = S_ENV;
               end
            end
         end
         S_ENV: begin
            if (mul_done) begin
               env_in   = env_ff - mul_prod[ENV_W-1:0];
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            target_in = (env_ff > {thr_ff, ENV_FRAC'(0)}) ? floor_g : UNITY;
            state_in  = S_GSEL;
         end
         S_GSEL: begin
            if (target_ff < g_ff) begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = MUL_W'(sat_unity(attack_ff));
               mul_req.mplier = MUL_W'(g_ff - target_ff);
               up_in          = 1'b0;
               hold_in        = hold_samples_ff;
               state_in       = S_GMUL;
            end else if (hold_ff != '0) begin
               hold_in  = hold_ff - HOLD_W'(1);
               state_in = S_CLAMP;
            end else begin
               mul_req.start  = 1'b1;
               mul_req.mcand  = MUL_W'(sat_unity(release_ff));
               mul_req.mplier = MUL_W'(target_ff - g_ff);
               up_in          = 1'b1;
               state_in       = S_GMUL;
            end
         end
         S_GMUL: begin
            if (mul_done) begin
               g_in     = up_ff ? (g_ff + GAIN_W'(mul_prod)) : (g_ff - GAIN_W'(mul_prod));
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            g_in           = g_clamp;
            mul_req.start  = 1'b1;
            mul_req.mcand  = MUL_W'(g_clamp);
            mul_req.mplier = MUL_W'(pmag_ff);
            state_in       = S_OMUL;
         end
         S_OMUL: begin
            if (mul_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_gain_in  = g_ff;
               rsp_y_in     = neg_ff ? (~mul_prod[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1)) : y_pos;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         thr_ff          <= THR_W'(3277);
         min_gain_ff     <= COEF_W'(4194304);
         attack_ff       <= COEF_W'(345612);
         release_ff      <= COEF_W'(1165);
         hold_samples_ff <= HOLD_W'(4800);
         decay_ff        <= COEF_W'(34915);
         env_ff          <= '0;
         g_ff            <= UNITY;
         hold_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         env_ff       <= env_in;
         g_ff         <= g_in;
         hold_ff      <= hold_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_THRESHOLD: thr_ff          <= csr_wdata[THR_W-1:0];
               CSR_MIN_GAIN:  min_gain_ff     <= csr_wdata[COEF_W-1:0];
               CSR_ATTACK:    attack_ff       <= csr_wdata[COEF_W-1:0];
               CSR_RELEASE:   release_ff      <= csr_wdata[COEF_W-1:0];
               CSR_HOLD:      hold_samples_ff <= csr_wdata[HOLD_W-1:0];
               CSR_ENV_DECAY: decay_ff        <= csr_wdata[COEF_W-1:0];
               default: begin
               end
            endcase
         end
      end
      target_ff   <= target_in;
      up_ff       <= up_in;
      neg_ff      <= neg_in;
      pmag_ff     <= pmag_in;
      rsp_gain_ff <= rsp_gain_in;
      rsp_y_ff    <= rsp_y_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_gain          = rsp_gain_ff;
   assign rsp_ducked_sample = rsp_y_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block still idle after accepting an item");
   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> state_ff == S_ENV || state_ff == S_GMUL || state_ff == S_OMUL)
      else $error("multiplier finished outside a waiting state");
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result loaded outside the output step");
   a_gain_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_gain_ff <= UNITY)
      else $error("gain above unity");

endmodule
